/* hdl/gve_pkg.sv */
// ----------------------------------------------------------------------------
// gve_pkg
// Shared codes and types for the grid velocity extrapolation block.
// ----------------------------------------------------------------------------
package gve_pkg;

	localparam int MAX_X_DEF = 32;
	localparam int MAX_Y_DEF = 32;
	localparam int MAX_Z_DEF = 32;

	// command codes
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_RUN  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	// cell status codes
	localparam logic [1:0] ST_UNKNOWN = 2'd0;
	localparam logic [1:0] ST_WAITING = 2'd1;
	localparam logic [1:0] ST_KNOWN   = 2'd2;
	localparam logic [1:0] ST_DONE    = 2'd3;

	// register indexes
	localparam logic [2:0] REG_SIZE_X = 3'd0;
	localparam logic [2:0] REG_SIZE_Y = 3'd1;
	localparam logic [2:0] REG_SIZE_Z = 3'd2;
	localparam logic [2:0] REG_LAYERS = 3'd3;

	localparam logic [5:0] SIZE_RST   = 6'd32;
	localparam logic [7:0] LAYERS_RST = 8'd1;

	typedef enum logic [3:0] {
		S_IDLE, S_RD_SELF, S_CHK_SELF, S_RD_NB, S_CHK_NB,
		S_DIVGO, S_DIV, S_WR_SELF, S_NEXT, S_FIN
	} seq_state_t;

	typedef enum logic [1:0] {
		PH_RB, PH_P1, PH_P2, PH_P3
	} phase_t;

	typedef struct packed {
		logic busy;
		logic done;
	} seq_stat_t;

endpackage

/* hdl/grid_velocity_extrapolation.sv */
// ----------------------------------------------------------------------------
// grid_velocity_extrapolation
// Loads a 3D velocity grid and extends known values outward layer by layer.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: a request is taken at a clock edge with start high and
//    busy low. Load writes a cell (one per cycle, no result). Read returns the
//    cell in the cycle after the request on the result ports with strobe high;
//    reads can follow back to back. Unused command code 3 is dropped.
//  - Run: busy rises the cycle after the request and stays high while the
//    sequencer walks the grid. Each cell visit steps through address,
//    registered data and advance. The status rebuild visits every cell in
//    use; each layer makes three passes over the interior. In the first pass
//    each known cell also takes six neighbor reads and a self write; in the
//    second each waiting cell takes six neighbor reads and, if a neighbor is
//    known, a division and a value write.
//  - A strobe with result_kind high marks the end; busy falls the cycle after.
//  - Config: cfg_ready is always high; write sizes and layer count while idle.
//  - Reset clears registers only; the grid memories are not cleared, so cells
//    must be loaded before they are read or run over.
//  - Results last one cycle and cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module grid_velocity_extrapolation #(
	parameter int MAX_X = gve_pkg::MAX_X_DEF,
	parameter int MAX_Y = gve_pkg::MAX_Y_DEF,
	parameter int MAX_Z = gve_pkg::MAX_Z_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic [4:0]         cell_x,
	input  logic [4:0]         cell_y,
	input  logic [4:0]         cell_z,
	input  logic signed [31:0] cell_value,
	input  logic               cell_valid,
	output logic               strobe,
	output logic               result_kind,
	output logic signed [31:0] read_value,
	output logic               is_known,
	output logic               in_range,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [7:0]         cfg_data
);
	localparam int XW = $clog2(MAX_X);
	localparam int YW = $clog2(MAX_Y);
	localparam int ZW = $clog2(MAX_Z);
	localparam int AW = XW + YW + ZW;
	localparam int DEPTH = 1 << AW;

	logic [5:0] size_x_q, size_y_q, size_z_q;
	logic [7:0] layers_q;
	logic [8:0] eff_x, eff_y, eff_z;
	logic       in_grid, accept, rd_pend_q, inr_q;
	logic [AW-1:0] cmd_a, seq_ra, seq_wa;
	logic       s_st_we, s_vv_we;
	logic [1:0] s_st_wd, st_q;
	logic [32:0] s_vv_wd, vv_q;
	logic       vv_we;
	gve_pkg::seq_stat_t stat;

	// clamp a size register to 1..MAX
	function automatic logic [8:0] clamp(input logic [5:0] s, input logic [8:0] mx);
		logic [8:0] v;
		v = {3'b000, s};
		if (v == 9'd0) v = 9'd1;
		if (v > mx) v = mx;
		return v;
	endfunction

	assign eff_x = clamp(size_x_q, 9'(MAX_X));
	assign eff_y = clamp(size_y_q, 9'(MAX_Y));
	assign eff_z = clamp(size_z_q, 9'(MAX_Z));
	assign in_grid = ({4'd0, cell_x} < eff_x) && ({4'd0, cell_y} < eff_y) &&
		({4'd0, cell_z} < eff_z);
	assign cmd_a = {ZW'({4'd0, cell_z}), YW'({4'd0, cell_y}), XW'({4'd0, cell_x})};

	assign busy      = stat.busy;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q  <= gve_pkg::SIZE_RST;
			size_y_q  <= gve_pkg::SIZE_RST;
			size_z_q  <= gve_pkg::SIZE_RST;
			layers_q  <= gve_pkg::LAYERS_RST;
			rd_pend_q <= 1'b0;
			inr_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					gve_pkg::REG_SIZE_X: size_x_q <= cfg_data[5:0];
					gve_pkg::REG_SIZE_Y: size_y_q <= cfg_data[5:0];
					gve_pkg::REG_SIZE_Z: size_z_q <= cfg_data[5:0];
					gve_pkg::REG_LAYERS: layers_q <= cfg_data;
					default: ;
				endcase
			end
			rd_pend_q <= accept && (command == gve_pkg::CMD_READ);
			inr_q     <= in_grid;
		end
	end

	// value memory write: load request or sequencer averaging
	assign vv_we = s_vv_we || (accept && command == gve_pkg::CMD_LOAD && in_grid);

	gve_ram #(.W(33), .D(DEPTH)) u_vv_ram (
		.clk   (clk),
		.we    (vv_we),
		.waddr (s_vv_we ? seq_wa : cmd_a),
		.wdata (s_vv_we ? s_vv_wd : {cell_valid, cell_value}),
		.raddr (busy ? seq_ra : cmd_a),
		.rdata (vv_q)
	);

	gve_ram #(.W(2), .D(DEPTH)) u_st_ram (
		.clk   (clk),
		.we    (s_st_we),
		.waddr (seq_wa),
		.wdata (s_st_wd),
		.raddr (busy ? seq_ra : cmd_a),
		.rdata (st_q)
	);

	gve_seq #(.XW(XW), .YW(YW), .ZW(ZW)) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.run      (accept && command == gve_pkg::CMD_RUN),
		.lim_x    (XW'(eff_x - 9'd1)),
		.lim_y    (YW'(eff_y - 9'd1)),
		.lim_z    (ZW'(eff_z - 9'd1)),
		.thin     ((eff_x < 9'd3) || (eff_y < 9'd3) || (eff_z < 9'd3)),
		.layers   (layers_q),
		.st_rdata (st_q),
		.vv_rdata (vv_q),
		.rd_addr  (seq_ra),
		.wr_addr  (seq_wa),
		.st_we    (s_st_we),
		.st_wdata (s_st_wd),
		.vv_we    (s_vv_we),
		.vv_wdata (s_vv_wd),
		.stat     (stat)
	);

	// result ports
	assign strobe      = rd_pend_q || stat.done;
	assign result_kind = stat.done;
	assign in_range    = rd_pend_q && inr_q;
	assign read_value  = in_range ? vv_q[31:0] : 32'sd0;
	assign is_known    = in_range && (st_q == gve_pkg::ST_KNOWN);
endmodule

/* hdl/gve_ram.sv */
// ----------------------------------------------------------------------------
// gve_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gve_ram #(
	parameter int W = 32,
	parameter int D = 1024
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* hdl/gve_div.sv */
// ----------------------------------------------------------------------------
// gve_div
// Signed sum divided by a small count, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module gve_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [34:0] dividend,
	input  logic [2:0]         divisor,
	output logic               done,
	output logic [31:0]        quot
);
	logic [34:0] q_q;
	logic [3:0]  rem_q;
	logic [2:0]  dv_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [3:0]  rem_sh;
	logic        ge;
	logic [34:0] q_nx;

	assign rem_sh = {rem_q[2:0], q_q[34]};
	assign ge     = rem_sh >= {1'b0, dv_q};
	assign q_nx   = {q_q[33:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd34) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[34];
			q_q   <= dividend[34] ? 35'(-dividend) : dividend;
			rem_q <= '0;
			dv_q  <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? rem_sh - {1'b0, dv_q} : rem_sh;
			q_q   <= q_nx;
			if (cnt_q == 6'd34) begin
				quot <= neg_q ? 32'(-q_nx) : q_nx[31:0];
			end
		end
	end
endmodule

/* hdl/gve_seq.sv */
// ----------------------------------------------------------------------------
// gve_seq
// Run sequencer: status rebuild and layered sweeps over the grid memories.
// ----------------------------------------------------------------------------
module gve_seq #(
	parameter int XW = 5,
	parameter int YW = 5,
	parameter int ZW = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  run,
	input  logic [XW-1:0]         lim_x,
	input  logic [YW-1:0]         lim_y,
	input  logic [ZW-1:0]         lim_z,
	input  logic                  thin,
	input  logic [7:0]            layers,
	input  logic [1:0]            st_rdata,
	input  logic [32:0]           vv_rdata,
	output logic [XW+YW+ZW-1:0]   rd_addr,
	output logic [XW+YW+ZW-1:0]   wr_addr,
	output logic                  st_we,
	output logic [1:0]            st_wdata,
	output logic                  vv_we,
	output logic [32:0]           vv_wdata,
	output gve_pkg::seq_stat_t    stat
);
	localparam int AW = XW + YW + ZW;

	gve_pkg::seq_state_t state_q, state_nx;
	gve_pkg::phase_t     phase_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [ZW-1:0] z_q;
	logic [2:0]    d_q;
	logic [7:0]    l_q;
	logic          any_q;
	logic          sv_q;
	logic signed [34:0] sum_q;
	logic [2:0]    cnt_q;
	logic [AW-1:0] self_a, nb_a;
	logic [XW-1:0] hx;
	logic [YW-1:0] hy;
	logic [ZW-1:0] hz;
	logic          lo, last, fin_now, border;
	logic          div_start, div_done;
	logic [31:0]   quot;

	assign lo   = (phase_q != gve_pkg::PH_RB);
	assign hx   = lo ? lim_x - XW'(1) : lim_x;
	assign hy   = lo ? lim_y - YW'(1) : lim_y;
	assign hz   = lo ? lim_z - ZW'(1) : lim_z;
	assign last = (x_q == hx) && (y_q == hy) && (z_q == hz);
	assign fin_now = last && (((phase_q == gve_pkg::PH_RB) && (thin || layers == 8'd0)) ||
		((phase_q == gve_pkg::PH_P3) && (l_q == layers - 8'd1)));
	assign border = (x_q == '0) || (y_q == '0) || (z_q == '0) ||
		(x_q == lim_x) || (y_q == lim_y) || (z_q == lim_z);
	assign self_a = {z_q, y_q, x_q};

	always_comb begin
		nb_a = self_a;
		case (d_q)
			3'd0: nb_a = {z_q, y_q, x_q - XW'(1)};
			3'd1: nb_a = {z_q, y_q, x_q + XW'(1)};
			3'd2: nb_a = {z_q, y_q - YW'(1), x_q};
			3'd3: nb_a = {z_q, y_q + YW'(1), x_q};
			3'd4: nb_a = {z_q - ZW'(1), y_q, x_q};
			default: nb_a = {z_q + ZW'(1), y_q, x_q};
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			gve_pkg::S_IDLE: if (run) state_nx = gve_pkg::S_RD_SELF;
			gve_pkg::S_RD_SELF: state_nx = gve_pkg::S_CHK_SELF;
			gve_pkg::S_CHK_SELF: begin
				state_nx = gve_pkg::S_NEXT;
				if ((phase_q == gve_pkg::PH_P1 && st_rdata == gve_pkg::ST_KNOWN) ||
					(phase_q == gve_pkg::PH_P2 && st_rdata == gve_pkg::ST_WAITING))
					state_nx = gve_pkg::S_RD_NB;
			end
			gve_pkg::S_RD_NB: state_nx = gve_pkg::S_CHK_NB;
			gve_pkg::S_CHK_NB: begin
				if (d_q != 3'd5) begin
					state_nx = gve_pkg::S_RD_NB;
				end else if (phase_q == gve_pkg::PH_P1) begin
					state_nx = gve_pkg::S_WR_SELF;
				end else if (cnt_q == 3'd0 && st_rdata != gve_pkg::ST_KNOWN) begin
					state_nx = gve_pkg::S_NEXT;
				end else begin
					state_nx = gve_pkg::S_DIVGO;
				end
			end
			gve_pkg::S_DIVGO: state_nx = gve_pkg::S_DIV;
			gve_pkg::S_DIV: if (div_done) state_nx = gve_pkg::S_WR_SELF;
			gve_pkg::S_WR_SELF: state_nx = gve_pkg::S_NEXT;
			gve_pkg::S_NEXT: state_nx = fin_now ? gve_pkg::S_FIN : gve_pkg::S_RD_SELF;
			gve_pkg::S_FIN: state_nx = gve_pkg::S_IDLE;
			default: state_nx = gve_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		rd_addr   = self_a;
		wr_addr   = self_a;
		st_we     = 1'b0;
		st_wdata  = gve_pkg::ST_KNOWN;
		vv_we     = 1'b0;
		vv_wdata  = {sv_q, quot};
		div_start = 1'b0;
		stat.busy = (state_q != gve_pkg::S_IDLE);
		stat.done = (state_q == gve_pkg::S_FIN);
		case (state_q)
			gve_pkg::S_RD_NB: rd_addr = nb_a;
			gve_pkg::S_CHK_SELF: begin
				case (phase_q)
					gve_pkg::PH_RB: begin
						st_we    = 1'b1;
						st_wdata = vv_rdata[32] ? gve_pkg::ST_KNOWN :
							(border ? gve_pkg::ST_DONE : gve_pkg::ST_UNKNOWN);
					end
					gve_pkg::PH_P3: st_we = (st_rdata == gve_pkg::ST_WAITING);
					default: st_we = 1'b0;
				endcase
			end
			gve_pkg::S_CHK_NB: begin
				wr_addr  = nb_a;
				st_wdata = gve_pkg::ST_WAITING;
				st_we    = (phase_q == gve_pkg::PH_P1) && (st_rdata == gve_pkg::ST_UNKNOWN);
			end
			gve_pkg::S_DIVGO: div_start = 1'b1;
			gve_pkg::S_WR_SELF: begin
				st_wdata = gve_pkg::ST_DONE;
				st_we    = (phase_q == gve_pkg::PH_P1) && !any_q;
				vv_we    = (phase_q == gve_pkg::PH_P2);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gve_pkg::S_IDLE;
			phase_q <= gve_pkg::PH_RB;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			d_q <= '0;
			l_q <= '0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				gve_pkg::S_IDLE: if (run) begin
					phase_q <= gve_pkg::PH_RB;
					x_q <= '0;
					y_q <= '0;
					z_q <= '0;
					l_q <= '0;
				end
				gve_pkg::S_CHK_SELF: d_q <= '0;
				gve_pkg::S_CHK_NB: d_q <= d_q + 3'd1;
				gve_pkg::S_NEXT: begin
					if (last) begin
						x_q <= XW'(1);
						y_q <= YW'(1);
						z_q <= ZW'(1);
						case (phase_q)
							gve_pkg::PH_RB: phase_q <= gve_pkg::PH_P1;
							gve_pkg::PH_P1: phase_q <= gve_pkg::PH_P2;
							gve_pkg::PH_P2: phase_q <= gve_pkg::PH_P3;
							default: begin
								phase_q <= gve_pkg::PH_P1;
								l_q     <= l_q + 8'd1;
							end
						endcase
					end else if (x_q != hx) begin
						x_q <= x_q + XW'(1);
					end else begin
						x_q <= XW'(lo);
						if (y_q != hy) begin
							y_q <= y_q + YW'(1);
						end else begin
							y_q <= YW'(lo);
							z_q <= z_q + ZW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// payload accumulators
	always_ff @(posedge clk) begin
		if (state_q == gve_pkg::S_CHK_SELF) begin
			any_q <= 1'b0;
			sum_q <= '0;
			cnt_q <= '0;
			sv_q  <= vv_rdata[32];
		end else if (state_q == gve_pkg::S_CHK_NB) begin
			if (st_rdata == gve_pkg::ST_UNKNOWN || st_rdata == gve_pkg::ST_WAITING)
				any_q <= 1'b1;
			if (st_rdata == gve_pkg::ST_KNOWN) begin
				sum_q <= sum_q + 35'(signed'(vv_rdata[31:0]));
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	gve_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.done     (div_done),
		.quot     (quot)
	);

`ifndef SYNTH
	a_one_port: assert property (@(posedge clk) disable iff (!arst_n) !(st_we && vv_we))
		else $error("status and value written together");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == gve_pkg::S_DIV)
		else $error("divider finished outside wait");
	a_nb_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gve_pkg::S_CHK_NB |-> d_q <= 3'd5)
		else $error("neighbor index out of range");
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gve_pkg::S_DIVGO |-> cnt_q != 3'd0)
		else $error("division by zero count");
`endif
endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grid velocity extrapolation block. Each phase
// resizes the grid, loads every cell in use, runs the extrapolation and then
// mixes random loads, reads, runs and dropped commands. A scoreboard model
// predicts every read and run-finished strobe; results are checked in order.
// ----------------------------------------------------------------------------
module tb;

	localparam int NCELL = gve_pkg::MAX_X_DEF * gve_pkg::MAX_Y_DEF * gve_pkg::MAX_Z_DEF;
	localparam int QUIET_LIMIT = 400000;
	localparam int SETTLE = 8;            // quiet cycles needed before a register write or pause
	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_RUN = 1'b1;

	typedef enum logic [1:0] {IT_CMD, IT_CFG, IT_DRAIN} item_kind_t;

	typedef struct {
		item_kind_t        kind;
		logic [1:0]        cmd;
		logic [4:0]        x, y, z;
		logic signed [31:0] val;
		logic              vld;
		logic [2:0]        idx;
		logic [7:0]        data;
		int                pct;
	} request_t;

	typedef struct {
		logic              kind;
		logic signed [31:0] value;
		logic              known;
		logic              rng;
	} cell_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] command = gve_pkg::CMD_LOAD;
	logic [4:0] cell_x = '0, cell_y = '0, cell_z = '0;
	logic signed [31:0] cell_value = '0;
	logic cell_valid = 1'b0;
	logic strobe, result_kind, is_known, in_range;
	logic signed [31:0] read_value;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	always #1 clk = ~clk;

	grid_velocity_extrapolation u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z),
		.cell_value(cell_value), .cell_valid(cell_valid),
		.strobe(strobe), .result_kind(result_kind), .read_value(read_value),
		.is_known(is_known), .in_range(in_range),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	request_t pending[$];
	cell_result_t expected_results[$];
	int mismatches = 0;
	int n_reads = 0, n_runs = 0, n_loads = 0;

	task automatic add_pending(request_t r);
		pending.insert(pending.size(), r);
	endtask

	task automatic add_expected(cell_result_t e);
		expected_results.insert(expected_results.size(), e);
	endtask

	// ---------------- scoreboard model of the grid ----------------
	logic signed [31:0] m_value[NCELL];
	logic [1:0] m_status[NCELL];
	logic m_valid[NCELL];
	logic [5:0] m_sx = gve_pkg::SIZE_RST, m_sy = gve_pkg::SIZE_RST, m_sz = gve_pkg::SIZE_RST;
	logic [7:0] m_layers = gve_pkg::LAYERS_RST;
	int nb_step[6] = '{-1, 1, -gve_pkg::MAX_X_DEF, gve_pkg::MAX_X_DEF,
		-gve_pkg::MAX_X_DEF * gve_pkg::MAX_Y_DEF, gve_pkg::MAX_X_DEF * gve_pkg::MAX_Y_DEF};

	// size 0 acts as 1, anything past the array acts as the array size
	function automatic int eff(logic [5:0] s, int lim);
		if (s == 0) return 1;
		if (s > lim) return lim;
		return int'(s);
	endfunction

	function automatic int cell_addr(int x, int y, int z);
		return (z * gve_pkg::MAX_Y_DEF + y) * gve_pkg::MAX_X_DEF + x;
	endfunction

	task automatic extrapolate_grid();
		int w, h, d, a, cnt, nb;
		longint sum;
		bit border;
		w = eff(m_sx, gve_pkg::MAX_X_DEF);
		h = eff(m_sy, gve_pkg::MAX_Y_DEF);
		d = eff(m_sz, gve_pkg::MAX_Z_DEF);
		// status rebuild over every cell in use
		for (int z = 0; z < d; z++)
			for (int y = 0; y < h; y++)
				for (int x = 0; x < w; x++) begin
					a = cell_addr(x, y, z);
					border = x == 0 || y == 0 || z == 0 || x == w - 1 || y == h - 1 || z == d - 1;
					if (m_valid[a]) m_status[a] = gve_pkg::ST_KNOWN;
					else m_status[a] = border ? gve_pkg::ST_DONE : gve_pkg::ST_UNKNOWN;
				end
		if (w < 3 || h < 3 || d < 3) return;
		for (int l = 0; l < m_layers; l++) begin
			// mark unknown neighbours of known cells as waiting; known cells with none left become done
			for (int z = 1; z < d - 1; z++)
				for (int y = 1; y < h - 1; y++)
					for (int x = 1; x < w - 1; x++) begin
						a = cell_addr(x, y, z);
						if (m_status[a] == gve_pkg::ST_KNOWN) begin
							cnt = 0;
							for (int k = 0; k < 6; k++) begin
								nb = a + nb_step[k];
								if (m_status[nb] == gve_pkg::ST_UNKNOWN) begin
									m_status[nb] = gve_pkg::ST_WAITING;
									cnt++;
								end else if (m_status[nb] == gve_pkg::ST_WAITING) begin
									cnt++;
								end
							end
							if (cnt == 0) m_status[a] = gve_pkg::ST_DONE;
						end
					end
			// waiting cells take the truncated mean of known neighbours
			for (int z = 1; z < d - 1; z++)
				for (int y = 1; y < h - 1; y++)
					for (int x = 1; x < w - 1; x++) begin
						a = cell_addr(x, y, z);
						if (m_status[a] == gve_pkg::ST_WAITING) begin
							sum = 0;
							cnt = 0;
							for (int k = 0; k < 6; k++) begin
								nb = a + nb_step[k];
								if (m_status[nb] == gve_pkg::ST_KNOWN) begin
									sum += longint'(m_value[nb]);
									cnt++;
								end
							end
							if (cnt != 0) m_value[a] = 32'(sum / cnt);
						end
					end
			for (int z = 1; z < d - 1; z++)
				for (int y = 1; y < h - 1; y++)
					for (int x = 1; x < w - 1; x++) begin
						a = cell_addr(x, y, z);
						if (m_status[a] == gve_pkg::ST_WAITING) m_status[a] = gve_pkg::ST_KNOWN;
					end
		end
	endtask

	task automatic model_request(request_t r);
		cell_result_t e;
		int a;
		bit in_grid;
		in_grid = r.x < eff(m_sx, gve_pkg::MAX_X_DEF) && r.y < eff(m_sy, gve_pkg::MAX_Y_DEF) &&
			r.z < eff(m_sz, gve_pkg::MAX_Z_DEF);
		a = cell_addr(r.x, r.y, r.z);
		e = '{KIND_READ, 32'sd0, 1'b0, 1'b0};
		case (r.cmd)
			gve_pkg::CMD_LOAD: begin
				n_loads++;
				if (in_grid) begin
					m_value[a] = r.val;
					m_valid[a] = r.vld;
				end
			end
			gve_pkg::CMD_RUN: begin
				n_runs++;
				extrapolate_grid();
				e.kind = KIND_RUN;
				add_expected(e);
			end
			gve_pkg::CMD_READ: begin
				n_reads++;
				if (in_grid) begin
					e.value = m_value[a];
					e.known = m_status[a] == gve_pkg::ST_KNOWN;
					e.rng = 1'b1;
				end
				add_expected(e);
			end
			default: ;
		endcase
	endtask

	task automatic model_config(logic [2:0] idx, logic [7:0] data);
		case (idx)
			gve_pkg::REG_SIZE_X: m_sx = data[5:0];
			gve_pkg::REG_SIZE_Y: m_sy = data[5:0];
			gve_pkg::REG_SIZE_Z: m_sz = data[5:0];
			gve_pkg::REG_LAYERS: m_layers = data;
			default: ;
		endcase
	endtask

	// ---------------- driver ----------------
	request_t drv;
	int idle_pct = 0;
	int settle_cnt = 0;

	always @(posedge clk or negedge arst_n) begin
		logic acc, cacc, n_start, n_cfg;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			acc = start && !busy;
			cacc = cfg_valid && cfg_ready;
			if (acc) model_request(drv);
			if (cacc) model_config(cfg_index, cfg_data);
			n_start = start && !acc;
			n_cfg = cfg_valid && !cacc;
			if (!n_start && !n_cfg && pending.size() > 0) begin
				if (pending[0].kind == IT_CMD) begin
					if ($urandom_range(99) >= idle_pct) begin
						drv = pending.pop_front();
						n_start = 1'b1;
					end
				end else begin
					// register writes and pauses wait for a quiet block
					if (expected_results.size() == 0 && !busy && !acc && !cacc)
						settle_cnt++;
					else
						settle_cnt = 0;
					if (settle_cnt >= SETTLE) begin
						settle_cnt = 0;
						if (pending[0].kind == IT_CFG) begin
							cfg_index <= pending[0].idx;
							cfg_data <= pending[0].data;
							n_cfg = 1'b1;
						end else begin
							idle_pct = pending[0].pct;
						end
						void'(pending.pop_front());
					end
				end
			end
			start <= n_start;
			cfg_valid <= n_cfg;
			command <= drv.cmd;
			cell_x <= drv.x;
			cell_y <= drv.y;
			cell_z <= drv.z;
			cell_value <= drv.val;
			cell_valid <= drv.vld;
		end
	end

	// ---------------- monitor ----------------
	always @(posedge clk) begin
		cell_result_t e;
		if (arst_n && strobe) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0b value %0d", result_kind, read_value);
			end else begin
				e = expected_results.pop_front();
				if (result_kind !== e.kind || read_value !== e.value ||
						is_known !== e.known || in_range !== e.rng) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp kind %0b val %0d known %0b rng %0b, got %0b %0d %0b %0b",
							e.kind, e.value, e.known, e.rng,
							result_kind, read_value, is_known, in_range);
				end
			end
		end
	end

	// ---------------- watchdog ----------------
	int quiet = 0;
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || (cfg_valid && cfg_ready) || strobe)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", quiet);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------- stimulus generation ----------------
	// Generator keeps its own view of which entries were ever written, so it
	// never reads a cell whose value or status is still undefined.
	bit g_loaded[NCELL];
	bit g_status[NCELL];
	int g_w = 32, g_h = 32, g_d = 32;

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(7))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_cmd(logic [1:0] cmd, int x, int y, int z,
			logic signed [31:0] val, logic vld);
		request_t r;
		r = '{IT_CMD, cmd, x[4:0], y[4:0], z[4:0], val, vld, 3'd0, 8'd0, 0};
		add_pending(r);
		if (cmd == gve_pkg::CMD_LOAD && x < g_w && y < g_h && z < g_d)
			g_loaded[cell_addr(x, y, z)] = 1'b1;
		if (cmd == gve_pkg::CMD_RUN)
			for (int zz = 0; zz < g_d; zz++)
				for (int yy = 0; yy < g_h; yy++)
					for (int xx = 0; xx < g_w; xx++)
						g_status[cell_addr(xx, yy, zz)] = 1'b1;
	endtask

	task automatic push_ctl(item_kind_t k, logic [2:0] idx, logic [7:0] data, int pct);
		request_t r;
		r = '{k, gve_pkg::CMD_LOAD, 5'd0, 5'd0, 5'd0, 32'sd0, 1'b0, idx, data, pct};
		add_pending(r);
	endtask

	// read at an address outside the sizes in use
	task automatic push_outside_read();
		int x, y, z;
		x = $urandom_range(31);
		y = $urandom_range(31);
		z = $urandom_range(31);
		if (g_w < 32) x = $urandom_range(31, g_w);
		else if (g_h < 32) y = $urandom_range(31, g_h);
		else z = $urandom_range(31, g_d);
		push_cmd(gve_pkg::CMD_READ, x, y, z, $urandom, 1'($urandom_range(1)));
	endtask

	task automatic push_read(int x, int y, int z);
		if (g_loaded[cell_addr(x, y, z)] && g_status[cell_addr(x, y, z)])
			push_cmd(gve_pkg::CMD_READ, x, y, z, $urandom, 1'($urandom_range(1)));
		else
			push_outside_read();
	endtask

	task automatic grid_phase(logic [7:0] sx, logic [7:0] sy, logic [7:0] sz,
			logic [7:0] layers, int n_rand, int pct);
		int x, y, z, pick;
		push_ctl(IT_DRAIN, 3'd0, 8'd0, pct);
		push_ctl(IT_CFG, gve_pkg::REG_SIZE_X, sx, 0);
		push_ctl(IT_CFG, gve_pkg::REG_SIZE_Y, sy, 0);
		push_ctl(IT_CFG, gve_pkg::REG_SIZE_Z, sz, 0);
		push_ctl(IT_CFG, gve_pkg::REG_LAYERS, layers, 0);
		g_w = eff(sx[5:0], gve_pkg::MAX_X_DEF);
		g_h = eff(sy[5:0], gve_pkg::MAX_Y_DEF);
		g_d = eff(sz[5:0], gve_pkg::MAX_Z_DEF);
		// well-formed start: fill the whole grid, then extrapolate
		for (z = 0; z < g_d; z++)
			for (y = 0; y < g_h; y++)
				for (x = 0; x < g_w; x++)
					push_cmd(gve_pkg::CMD_LOAD, x, y, z, rand_value(), $urandom_range(99) < 30);
		push_cmd(gve_pkg::CMD_RUN, 0, 0, 0, $urandom, 1'b0);
		for (int i = 0; i < n_rand; i++) begin
			x = $urandom_range(g_w - 1);
			y = $urandom_range(g_h - 1);
			z = $urandom_range(g_d - 1);
			pick = $urandom_range(99);
			if (pick < 30)
				push_cmd(gve_pkg::CMD_LOAD, x, y, z, rand_value(), 1'($urandom_range(1)));
			else if (pick < 72)
				push_read(x, y, z);
			else if (pick < 80)
				push_cmd(gve_pkg::CMD_RUN, $urandom_range(31), $urandom_range(31),
					$urandom_range(31), $urandom, 1'($urandom_range(1)));
			else if (pick < 85)
				push_cmd(CMD_NONE, $urandom_range(31), $urandom_range(31),
					$urandom_range(31), $urandom, 1'($urandom_range(1)));
			else if (pick < 90)
				push_outside_read();
			else if (pick < 94)
				// pause until every outstanding result has come back
				push_ctl(IT_DRAIN, 3'd0, 8'd0, pct);
			else
				push_cmd(gve_pkg::CMD_LOAD, $urandom_range(31), $urandom_range(31),
					$urandom_range(31), rand_value(), 1'($urandom_range(1)));
		end
		for (z = 0; z < g_d; z++)
			for (y = 0; y < g_h; y++)
				for (x = 0; x < g_w; x++)
					push_read(x, y, z);
	endtask

	initial begin
		int c;
		// directed: 3x3x3 with a lone unknown centre between extreme neighbours
		push_ctl(IT_CFG, 3'd4, 8'hA5, 0);
		push_ctl(IT_CFG, 3'd7, 8'h5A, 0);
		push_ctl(IT_CFG, gve_pkg::REG_SIZE_X, 8'd3, 0);
		push_ctl(IT_CFG, gve_pkg::REG_SIZE_Y, 8'd3, 0);
		push_ctl(IT_CFG, gve_pkg::REG_SIZE_Z, 8'd3, 0);
		push_ctl(IT_CFG, gve_pkg::REG_LAYERS, 8'd1, 0);
		g_w = 3; g_h = 3; g_d = 3;
		for (int i = 0; i < 27; i++)
			push_cmd(gve_pkg::CMD_LOAD, i % 3, (i / 3) % 3, i / 9,
				(i % 2) ? 32'sh7FFFFFFF : 32'sh80000001, i != 13);
		push_cmd(gve_pkg::CMD_LOAD, 31, 31, 31, 32'sh1234, 1'b1);   // outside, dropped
		push_cmd(CMD_NONE, 31, 31, 31, -32'sd1, 1'b1);              // unused code
		push_cmd(gve_pkg::CMD_RUN, 0, 0, 0, 32'sd0, 1'b0);
		push_cmd(gve_pkg::CMD_READ, 1, 1, 1, 32'sd0, 1'b0);
		push_cmd(gve_pkg::CMD_READ, 0, 0, 0, 32'sd0, 1'b0);
		push_cmd(gve_pkg::CMD_READ, 31, 31, 31, 32'sd0, 1'b0);
		// phases: sizes, layers, random items, sender idle percentage
		grid_phase(8'd0, 8'd1, 8'd1, 8'd0, 10, 0);
		grid_phase(8'd63, 8'd1, 8'd1, 8'd2, 10, 45);
		grid_phase(8'd1, 8'd5, 8'd1, 8'd1, 10, 18);
		grid_phase(8'd1, 8'd1, 8'd4, 8'd3, 10, 0);
		grid_phase(8'd4, 8'd4, 8'd3, 8'd2, 20, 45);
		grid_phase(8'd4, 8'd4, 8'd4, 8'd255, 10, 18);
		grid_phase(8'd5, 8'd3, 8'd3, 8'd3, 20, 0);
		grid_phase(8'd3, 8'd3, 8'd0, 8'd2, 20, 45);
		grid_phase(8'd3, 8'd3, 8'd3, 8'd0, 10, 18);
		grid_phase(8'd4, 8'd3, 8'd4, 8'd4, 10, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		c = 0;
		while (pending.size() > 0 || start || cfg_valid) @(posedge clk);
		while (expected_results.size() > 0) @(posedge clk);
		while (c < 40) begin
			@(posedge clk);
			c++;
		end
		$display("covered %0d loads, %0d reads, %0d runs over ten grid shapes",
			n_loads, n_reads, n_runs);
		$display("sizes 0, 1, 3 to 5 and 63 clamped to 32, layers 0 to 255, sender idle 0/18/45 percent");
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
